// ===== rtl/core/swsfr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package swsfr_pkg;

    localparam int unsigned FRAME_BITS = 40;
    localparam int unsigned BIT_CNT_W  = 6;
    localparam int unsigned LIMIT_W    = 17;

    // Register indexes on the configuration port (word address).
    localparam logic [2:0] REG_CYCLES_PER_US   = 3'd0;
    localparam logic [2:0] REG_POWERUP_WAIT    = 3'd1;
    localparam logic [2:0] REG_START_LOW       = 3'd2;
    localparam logic [2:0] REG_SAMPLE_INTERVAL = 3'd3;
    localparam logic [2:0] REG_FRAME_TIMEOUT   = 3'd4;
    localparam logic [2:0] REG_BIT_THRESHOLD   = 3'd5;

    localparam logic [7:0]  RST_CYCLES_PER_US   = 8'd168;
    localparam logic [15:0] RST_POWERUP_WAIT    = 16'd100;
    localparam logic [15:0] RST_START_LOW       = 16'd2;
    localparam logic [15:0] RST_SAMPLE_INTERVAL = 16'd100;
    localparam logic [15:0] RST_FRAME_TIMEOUT   = 16'd2;
    localparam logic [7:0]  RST_BIT_THRESHOLD   = 8'd50;

    // Request kinds.
    localparam logic MODE_TICK = 1'b0;
    localparam logic MODE_EDGE = 1'b1;

    // Sequencer states.
    localparam logic [1:0] SEQ_POWERUP    = 2'd0;
    localparam logic [1:0] SEQ_IDLE       = 2'd1;
    localparam logic [1:0] SEQ_START_LOW  = 2'd2;
    localparam logic [1:0] SEQ_WAIT_FRAME = 2'd3;

    // Capture states.
    localparam logic [2:0] CAP_RESP_FALL  = 3'd0;
    localparam logic [2:0] CAP_RESP_RISE  = 3'd1;
    localparam logic [2:0] CAP_FIRST_FALL = 3'd2;
    localparam logic [2:0] CAP_BIT_RISE   = 3'd3;
    localparam logic [2:0] CAP_BIT_FALL   = 3'd4;

    // Frame events.
    localparam logic [1:0] EV_NONE    = 2'd0;
    localparam logic [1:0] EV_OK      = 2'd1;
    localparam logic [1:0] EV_BAD_SUM = 2'd2;
    localparam logic [1:0] EV_FAIL    = 2'd3;

    typedef struct packed {
        logic [LIMIT_W-1:0] bit_limit;
        logic [15:0]        start_low_ticks;
        logic [15:0]        sample_interval_ticks;
        logic [15:0]        frame_timeout_ticks;
    } t_cfg;

    typedef struct packed {
        logic        line_drive_low;
        logic        listening;
        logic [11:0] humidity_tenths;
        logic [11:0] temperature_tenths;
        logic        data_valid;
        logic [1:0]  frame_event;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/core/single_wire_sensor_frame_reader.sv =====
// Channel   | Direction | Handshake                 | Payload
// ----------+-----------+---------------------------+---------------------------------------
// request   | in        | i_in_valid / o_in_ready   | i_mode, i_line_level, i_cycle_stamp
// result    | out       | o_out_valid / i_out_ready | o_line_drive_low, o_listening,
//           |           |                           | o_humidity_tenths, o_temperature_tenths,
//           |           |                           | o_data_valid, o_frame_event
// config    | in        | APB psel/penable/pready   | paddr, pwdata, prdata
//
// Each request gives one result, held first in the input register and then in the
// result register. A request can be accepted every cycle unless the result stalls.
// The sequencer and capture state update from the request in the input register.
// Reset is synchronous and active low; the state returns to the power-up wait.
// A stalled result holds the input register, which fills and then drops o_in_ready.
`timescale 1ns / 1ps
`default_nettype none

module single_wire_sensor_frame_reader (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_mode,
    input  wire logic        i_line_level,
    input  wire logic [31:0] i_cycle_stamp,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_line_drive_low,
    output logic             o_listening,
    output logic [11:0]      o_humidity_tenths,
    output logic [11:0]      o_temperature_tenths,
    output logic             o_data_valid,
    output logic [1:0]       o_frame_event,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    logic               r_in_valid;
    logic               r_in_mode;
    logic               r_in_level;
    logic [31:0]        r_in_stamp;
    logic               r_out_valid;
    swsfr_pkg::t_result r_out;
    swsfr_pkg::t_result w_res;
    swsfr_pkg::t_cfg    w_cfg;
    logic               w_advance;
    logic               w_step;

    assign w_advance  = !r_out_valid || i_out_ready;
    assign w_step     = r_in_valid && w_advance;
    assign o_in_ready = !r_in_valid || w_advance;

    swsfr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    swsfr_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_mode  (r_in_mode),
        .i_level (r_in_level),
        .i_stamp (r_in_stamp),
        .i_cfg   (w_cfg),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_mode  <= i_mode;
            r_in_level <= i_line_level;
            r_in_stamp <= i_cycle_stamp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_line_drive_low     = r_out.line_drive_low;
    assign o_listening          = r_out.listening;
    assign o_humidity_tenths    = r_out.humidity_tenths;
    assign o_temperature_tenths = r_out.temperature_tenths;
    assign o_data_valid         = r_out.data_valid;
    assign o_frame_event        = r_out.frame_event;

`ifndef ASSERT_OFF
    // The start pulse and listening never overlap.
    a_drive_vs_listen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_line_drive_low && o_listening))
        else $error("line driven low while listening");

    // An accepted frame always leaves stored readings marked valid.
    a_ok_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_frame_event == swsfr_pkg::EV_OK) |-> o_data_valid)
        else $error("frame accepted without data valid");

    // A new result only appears when a request sat in the input register.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_in_valid))
        else $error("result without a request");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/swsfr_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module swsfr_cfg (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [4:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic      [31:0]          prdata,
    output logic                      pready,
    output swsfr_pkg::t_cfg           o_cfg
);

    logic [7:0]  r_cycles_per_us;
    logic [15:0] r_powerup_wait;
    logic [15:0] r_start_low;
    logic [15:0] r_sample_interval;
    logic [15:0] r_frame_timeout;
    logic [7:0]  r_bit_threshold;
    logic [swsfr_pkg::LIMIT_W-1:0] r_limit;
    logic [swsfr_pkg::LIMIT_W-1:0] n_limit;
    logic [7:0]  n_cycles_per_us;
    logic [7:0]  n_bit_threshold;
    logic [7:0]  w_cpu;
    logic        w_write;
    logic [2:0]  w_index;

    assign pready  = 1'b1;
    assign w_write = psel & penable & pwrite;
    assign w_index = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cycles_per_us   <= swsfr_pkg::RST_CYCLES_PER_US;
            r_powerup_wait    <= swsfr_pkg::RST_POWERUP_WAIT;
            r_start_low       <= swsfr_pkg::RST_START_LOW;
            r_sample_interval <= swsfr_pkg::RST_SAMPLE_INTERVAL;
            r_frame_timeout   <= swsfr_pkg::RST_FRAME_TIMEOUT;
            r_bit_threshold   <= swsfr_pkg::RST_BIT_THRESHOLD;
        end else if (w_write) begin
            case (w_index)
                swsfr_pkg::REG_CYCLES_PER_US:   r_cycles_per_us   <= pwdata[7:0];
                swsfr_pkg::REG_POWERUP_WAIT:    r_powerup_wait    <= pwdata[15:0];
                swsfr_pkg::REG_START_LOW:       r_start_low       <= pwdata[15:0];
                swsfr_pkg::REG_SAMPLE_INTERVAL: r_sample_interval <= pwdata[15:0];
                swsfr_pkg::REG_FRAME_TIMEOUT:   r_frame_timeout   <= pwdata[15:0];
                swsfr_pkg::REG_BIT_THRESHOLD:   r_bit_threshold   <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    assign n_cycles_per_us = (w_write && w_index == swsfr_pkg::REG_CYCLES_PER_US) ?
                             pwdata[7:0] : r_cycles_per_us;
    assign n_bit_threshold = (w_write && w_index == swsfr_pkg::REG_BIT_THRESHOLD) ?
                             pwdata[7:0] : r_bit_threshold;

    // The bit decision limit is kept in a register so that the multiply
    // stays off the per-request path. It is taken from the next register
    // values, so it changes at the same edge as a write. A rate of zero
    // counts as one.
    assign w_cpu   = (n_cycles_per_us == 8'd0) ? 8'd1 : n_cycles_per_us;
    assign n_limit = ({8'd0, 1'b0, n_bit_threshold} + 17'd1) * {9'd0, w_cpu};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= ({9'd0, swsfr_pkg::RST_BIT_THRESHOLD} + 17'd1)
                       * {9'd0, swsfr_pkg::RST_CYCLES_PER_US};
        end else begin
            r_limit <= n_limit;
        end
    end

    always_comb begin
        case (w_index)
            swsfr_pkg::REG_CYCLES_PER_US:   prdata = {24'd0, r_cycles_per_us};
            swsfr_pkg::REG_POWERUP_WAIT:    prdata = {16'd0, r_powerup_wait};
            swsfr_pkg::REG_START_LOW:       prdata = {16'd0, r_start_low};
            swsfr_pkg::REG_SAMPLE_INTERVAL: prdata = {16'd0, r_sample_interval};
            swsfr_pkg::REG_FRAME_TIMEOUT:   prdata = {16'd0, r_frame_timeout};
            swsfr_pkg::REG_BIT_THRESHOLD:   prdata = {24'd0, r_bit_threshold};
            default:                        prdata = 32'd0;
        endcase
    end

    always_comb begin
        o_cfg.bit_limit             = r_limit;
        o_cfg.start_low_ticks       = r_start_low;
        o_cfg.sample_interval_ticks = r_sample_interval;
        o_cfg.frame_timeout_ticks   = r_frame_timeout;
    end

endmodule

`default_nettype wire

// ===== rtl/core/swsfr_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

module swsfr_core (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_step,
    input  wire logic                 i_mode,
    input  wire logic                 i_level,
    input  wire logic [31:0]          i_stamp,
    input  wire swsfr_pkg::t_cfg      i_cfg,
    output swsfr_pkg::t_result        o_res
);

    logic [1:0]  r_seq,        n_seq;
    logic [2:0]  r_cap,        n_cap;
    logic [15:0] r_cnt,        n_cnt;
    logic [swsfr_pkg::FRAME_BITS-1:0] r_shift, n_shift;
    logic [swsfr_pkg::BIT_CNT_W-1:0]  r_bitcnt, n_bitcnt;
    logic        r_done,       n_done;
    logic        r_err,        n_err;
    logic        r_active,     n_active;
    logic [31:0] r_rise,       n_rise;
    logic [11:0] r_hum,        n_hum;
    logic [11:0] r_temp,       n_temp;
    logic        r_valid_seen, n_valid_seen;
    logic [1:0]  n_event;

    logic [31:0] w_high;
    logic        w_bit;
    logic [swsfr_pkg::BIT_CNT_W-1:0] w_bitcnt_inc;
    logic [7:0]  w_b0, w_b1, w_b2, w_b3, w_b4;
    logic [9:0]  w_sum;
    logic        w_sum_ok;
    logic [11:0] w_hum_calc, w_temp_calc;

    assign w_high       = i_stamp - r_rise;
    assign w_bit        = (w_high >= {15'd0, i_cfg.bit_limit});
    assign w_bitcnt_inc = r_bitcnt + 1'b1;

    assign w_b0 = r_shift[39:32];
    assign w_b1 = r_shift[31:24];
    assign w_b2 = r_shift[23:16];
    assign w_b3 = r_shift[15:8];
    assign w_b4 = r_shift[7:0];
    assign w_sum    = {2'd0, w_b0} + {2'd0, w_b1} + {2'd0, w_b2} + {2'd0, w_b3};
    assign w_sum_ok = (w_sum[7:0] == w_b4);
    // Times ten as two shifted copies.
    assign w_hum_calc  = {1'b0, w_b0, 3'd0} + {3'd0, w_b0, 1'b0} + {4'd0, w_b1};
    assign w_temp_calc = {1'b0, w_b2, 3'd0} + {3'd0, w_b2, 1'b0} + {4'd0, w_b3};

    always_comb begin
        n_seq        = r_seq;
        n_cap        = r_cap;
        n_cnt        = r_cnt;
        n_shift      = r_shift;
        n_bitcnt     = r_bitcnt;
        n_done       = r_done;
        n_err        = r_err;
        n_active     = r_active;
        n_rise       = r_rise;
        n_hum        = r_hum;
        n_temp       = r_temp;
        n_valid_seen = r_valid_seen;
        n_event      = swsfr_pkg::EV_NONE;

        if (i_mode == swsfr_pkg::MODE_TICK) begin
            if (r_done) begin
                n_done = 1'b0;
                if (w_sum_ok) begin
                    n_hum        = w_hum_calc;
                    n_temp       = w_temp_calc;
                    n_valid_seen = 1'b1;
                    n_event      = swsfr_pkg::EV_OK;
                end else begin
                    n_event = swsfr_pkg::EV_BAD_SUM;
                end
                n_active = 1'b0;
                n_seq    = swsfr_pkg::SEQ_IDLE;
                n_cnt    = i_cfg.sample_interval_ticks;
            end else if (r_err) begin
                n_err    = 1'b0;
                n_event  = swsfr_pkg::EV_FAIL;
                n_active = 1'b0;
                n_seq    = swsfr_pkg::SEQ_IDLE;
                n_cnt    = i_cfg.sample_interval_ticks;
            end else begin
                case (r_seq)
                    swsfr_pkg::SEQ_POWERUP, swsfr_pkg::SEQ_IDLE: begin
                        if (r_cnt != 16'd0) begin
                            n_cnt = r_cnt - 16'd1;
                        end else begin
                            n_shift  = '0;
                            n_bitcnt = '0;
                            n_done   = 1'b0;
                            n_err    = 1'b0;
                            n_cap    = swsfr_pkg::CAP_RESP_FALL;
                            n_rise   = 32'd0;
                            n_seq    = swsfr_pkg::SEQ_START_LOW;
                            n_cnt    = i_cfg.start_low_ticks;
                        end
                    end
                    swsfr_pkg::SEQ_START_LOW: begin
                        // The pulse ends on the tick that counts down to zero,
                        // or at once if it was loaded with zero.
                        if (r_cnt > 16'd1) begin
                            n_cnt = r_cnt - 16'd1;
                        end else begin
                            n_shift  = '0;
                            n_bitcnt = '0;
                            n_done   = 1'b0;
                            n_err    = 1'b0;
                            n_cap    = swsfr_pkg::CAP_RESP_FALL;
                            n_rise   = 32'd0;
                            n_active = 1'b1;
                            n_seq    = swsfr_pkg::SEQ_WAIT_FRAME;
                            n_cnt    = i_cfg.frame_timeout_ticks;
                        end
                    end
                    default: begin
                        if (r_cnt != 16'd0) begin
                            n_cnt = r_cnt - 16'd1;
                        end else begin
                            n_event  = swsfr_pkg::EV_FAIL;
                            n_active = 1'b0;
                            n_seq    = swsfr_pkg::SEQ_IDLE;
                            n_cnt    = i_cfg.sample_interval_ticks;
                        end
                    end
                endcase
            end
        end else if (r_active) begin
            if (!i_level) begin
                case (r_cap)
                    swsfr_pkg::CAP_RESP_FALL:  n_cap = swsfr_pkg::CAP_RESP_RISE;
                    swsfr_pkg::CAP_FIRST_FALL: n_cap = swsfr_pkg::CAP_BIT_RISE;
                    swsfr_pkg::CAP_BIT_FALL: begin
                        n_shift  = {r_shift[swsfr_pkg::FRAME_BITS-2:0], w_bit};
                        n_bitcnt = w_bitcnt_inc;
                        if (w_bitcnt_inc >= swsfr_pkg::BIT_CNT_W'(swsfr_pkg::FRAME_BITS)) begin
                            n_active = 1'b0;
                            n_done   = 1'b1;
                        end else begin
                            n_cap = swsfr_pkg::CAP_BIT_RISE;
                        end
                    end
                    default: begin
                        n_active = 1'b0;
                        n_err    = 1'b1;
                    end
                endcase
            end else begin
                case (r_cap)
                    swsfr_pkg::CAP_RESP_RISE: n_cap = swsfr_pkg::CAP_FIRST_FALL;
                    swsfr_pkg::CAP_BIT_RISE: begin
                        n_rise = i_stamp;
                        n_cap  = swsfr_pkg::CAP_BIT_FALL;
                    end
                    default: begin
                        n_active = 1'b0;
                        n_err    = 1'b1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq        <= swsfr_pkg::SEQ_POWERUP;
            r_cap        <= swsfr_pkg::CAP_RESP_FALL;
            r_cnt        <= swsfr_pkg::RST_POWERUP_WAIT;
            r_shift      <= '0;
            r_bitcnt     <= '0;
            r_done       <= 1'b0;
            r_err        <= 1'b0;
            r_active     <= 1'b0;
            r_rise       <= 32'd0;
            r_hum        <= 12'd0;
            r_temp       <= 12'd0;
            r_valid_seen <= 1'b0;
        end else if (i_step) begin
            r_seq        <= n_seq;
            r_cap        <= n_cap;
            r_cnt        <= n_cnt;
            r_shift      <= n_shift;
            r_bitcnt     <= n_bitcnt;
            r_done       <= n_done;
            r_err        <= n_err;
            r_active     <= n_active;
            r_rise       <= n_rise;
            r_hum        <= n_hum;
            r_temp       <= n_temp;
            r_valid_seen <= n_valid_seen;
        end
    end

    always_comb begin
        o_res.line_drive_low     = (n_seq == swsfr_pkg::SEQ_START_LOW);
        o_res.listening          = n_active;
        o_res.humidity_tenths    = n_hum;
        o_res.temperature_tenths = n_temp;
        o_res.data_valid         = n_valid_seen;
        o_res.frame_event        = n_event;
    end

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;

    localparam int CLK_HALF_NS = 4;
    localparam int RESET_CYCLES = 7;
    localparam int SETTLE_CYCLES = 10;
    localparam int FRAME_EDGES = 83;

    // Addresses past the register list; writes there must change nothing.
    localparam logic [2:0] REG_SPARE_A = 3'd6;
    localparam logic [2:0] REG_SPARE_B = 3'd7;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic        i_mode = swsfr_pkg::MODE_TICK;
    logic        i_line_level = 1'b0;
    logic [31:0] i_cycle_stamp = 32'd0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b1;
    logic        o_line_drive_low;
    logic        o_listening;
    logic [11:0] o_humidity_tenths;
    logic [11:0] o_temperature_tenths;
    logic        o_data_valid;
    logic [1:0]  o_frame_event;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = 5'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    single_wire_sensor_frame_reader uut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_in_valid),
        .o_in_ready           (o_in_ready),
        .i_mode               (i_mode),
        .i_line_level         (i_line_level),
        .i_cycle_stamp        (i_cycle_stamp),
        .o_out_valid          (o_out_valid),
        .i_out_ready          (i_out_ready),
        .o_line_drive_low     (o_line_drive_low),
        .o_listening          (o_listening),
        .o_humidity_tenths    (o_humidity_tenths),
        .o_temperature_tenths (o_temperature_tenths),
        .o_data_valid         (o_data_valid),
        .o_frame_event        (o_frame_event),
        .psel                 (psel),
        .penable              (penable),
        .pwrite               (pwrite),
        .paddr                (paddr),
        .pwdata               (pwdata),
        .prdata               (prdata),
        .pready               (pready)
    );

    always #(CLK_HALF_NS) i_clk = ~i_clk;

    // Register copies as the sensor reader should hold them.
    logic [7:0]  cfg_cpu;
    logic [15:0] cfg_powerup;
    logic [15:0] cfg_start_low;
    logic [15:0] cfg_interval;
    logic [15:0] cfg_timeout;
    logic [7:0]  cfg_thr;

    // Sequencer and capture state of the sensor reader.
    logic [1:0]  seq_st;
    logic [2:0]  cap_st;
    logic [15:0] tick_left;
    logic [39:0] shift_bits;
    logic [5:0]  bits_in;
    logic        frame_done;
    logic        frame_err;
    logic        capturing;
    logic [31:0] rise_at;
    logic [11:0] hum_keep;
    logic [11:0] temp_keep;
    logic        seen_good;

    swsfr_pkg::t_result due_results[$];
    int          mismatch_cnt = 0;
    int          result_idx = 0;
    int          req_cnt = 0;
    bit          idle_on = 1'b1;
    logic [31:0] line_ts = 32'd0;
    swsfr_pkg::t_result got;
    swsfr_pkg::t_result want;

    function automatic logic [31:0] bit_limit();
        logic [31:0] cpu;
        cpu = (cfg_cpu == 8'd0) ? 32'd1 : {24'd0, cfg_cpu};
        return ({24'd0, cfg_thr} + 32'd1) * cpu;
    endfunction

    function automatic void drop_capture();
        shift_bits = 40'd0;
        bits_in = 6'd0;
        frame_done = 1'b0;
        frame_err = 1'b0;
        cap_st = swsfr_pkg::CAP_RESP_FALL;
        rise_at = 32'd0;
    endfunction

    function automatic void enter_idle();
        capturing = 1'b0;
        seq_st = swsfr_pkg::SEQ_IDLE;
        tick_left = cfg_interval;
    endfunction

    function automatic void capture_abort();
        capturing = 1'b0;
        frame_err = 1'b1;
    endfunction

    // Applies one accepted request and queues the result it must produce.
    function automatic void reader_step(input logic mode, input logic level,
                                        input logic [31:0] stamp);
        swsfr_pkg::t_result r;
        logic [1:0] ev;
        logic [7:0] sum;
        ev = swsfr_pkg::EV_NONE;
        if (mode == swsfr_pkg::MODE_TICK) begin
            if (frame_done) begin
                frame_done = 1'b0;
                sum = shift_bits[39:32] + shift_bits[31:24] + shift_bits[23:16]
                    + shift_bits[15:8];
                if (sum == shift_bits[7:0]) begin
                    hum_keep = shift_bits[39:32] * 12'd10 + shift_bits[31:24];
                    temp_keep = shift_bits[23:16] * 12'd10 + shift_bits[15:8];
                    seen_good = 1'b1;
                    ev = swsfr_pkg::EV_OK;
                end else begin
                    ev = swsfr_pkg::EV_BAD_SUM;
                end
                enter_idle();
            end else if (frame_err) begin
                frame_err = 1'b0;
                enter_idle();
                ev = swsfr_pkg::EV_FAIL;
            end else begin
                case (seq_st)
                    swsfr_pkg::SEQ_POWERUP, swsfr_pkg::SEQ_IDLE: begin
                        if (tick_left != 16'd0) begin
                            tick_left = tick_left - 16'd1;
                        end else begin
                            drop_capture();
                            seq_st = swsfr_pkg::SEQ_START_LOW;
                            tick_left = cfg_start_low;
                        end
                    end
                    swsfr_pkg::SEQ_START_LOW: begin
                        if (tick_left != 16'd0)
                            tick_left = tick_left - 16'd1;
                        if (tick_left == 16'd0) begin
                            drop_capture();
                            capturing = 1'b1;
                            seq_st = swsfr_pkg::SEQ_WAIT_FRAME;
                            tick_left = cfg_timeout;
                        end
                    end
                    default: begin
                        if (tick_left != 16'd0) begin
                            tick_left = tick_left - 16'd1;
                        end else begin
                            enter_idle();
                            ev = swsfr_pkg::EV_FAIL;
                        end
                    end
                endcase
            end
        end else if (capturing) begin
            if (level == 1'b0) begin
                case (cap_st)
                    swsfr_pkg::CAP_RESP_FALL: cap_st = swsfr_pkg::CAP_RESP_RISE;
                    swsfr_pkg::CAP_FIRST_FALL: cap_st = swsfr_pkg::CAP_BIT_RISE;
                    swsfr_pkg::CAP_BIT_FALL: begin
                        // The subtraction wraps, so a stamp counter rollover is harmless.
                        shift_bits = {shift_bits[38:0], (stamp - rise_at) >= bit_limit()};
                        bits_in = bits_in + 6'd1;
                        if (bits_in >= swsfr_pkg::FRAME_BITS) begin
                            capturing = 1'b0;
                            frame_done = 1'b1;
                        end else begin
                            cap_st = swsfr_pkg::CAP_BIT_RISE;
                        end
                    end
                    default: capture_abort();
                endcase
            end else begin
                case (cap_st)
                    swsfr_pkg::CAP_RESP_RISE: cap_st = swsfr_pkg::CAP_FIRST_FALL;
                    swsfr_pkg::CAP_BIT_RISE: begin
                        rise_at = stamp;
                        cap_st = swsfr_pkg::CAP_BIT_FALL;
                    end
                    default: capture_abort();
                endcase
            end
        end
        r.line_drive_low = (seq_st == swsfr_pkg::SEQ_START_LOW);
        r.listening = capturing;
        r.humidity_tenths = hum_keep;
        r.temperature_tenths = temp_keep;
        r.data_valid = seen_good;
        r.frame_event = ev;
        due_results.push_back(r);
    endfunction

    function automatic logic [31:0] cfg_word(input logic [2:0] idx);
        case (idx)
            swsfr_pkg::REG_CYCLES_PER_US:   return {24'd0, cfg_cpu};
            swsfr_pkg::REG_POWERUP_WAIT:    return {16'd0, cfg_powerup};
            swsfr_pkg::REG_START_LOW:       return {16'd0, cfg_start_low};
            swsfr_pkg::REG_SAMPLE_INTERVAL: return {16'd0, cfg_interval};
            swsfr_pkg::REG_FRAME_TIMEOUT:   return {16'd0, cfg_timeout};
            swsfr_pkg::REG_BIT_THRESHOLD:   return {24'd0, cfg_thr};
            default:                        return 32'd0;
        endcase
    endfunction

    // Result checker: every accepted result is matched against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = {o_line_drive_low, o_listening, o_humidity_tenths, o_temperature_tenths,
                   o_data_valid, o_frame_event};
            if (due_results.size() == 0) begin
                if (mismatch_cnt < 10)
                    $display("result %0d arrived with nothing expected", result_idx);
                mismatch_cnt++;
            end else begin
                want = due_results.pop_front();
                if (got !== want) begin
                    if (mismatch_cnt < 10)
                        $display({"result %0d (expected/actual): drive %0b/%0b listen %0b/%0b",
                                  " hum %0d/%0d temp %0d/%0d valid %0b/%0b event %0d/%0d"},
                                 result_idx, want.line_drive_low, got.line_drive_low,
                                 want.listening, got.listening,
                                 want.humidity_tenths, got.humidity_tenths,
                                 want.temperature_tenths, got.temperature_tenths,
                                 want.data_valid, got.data_valid,
                                 want.frame_event, got.frame_event);
                    mismatch_cnt++;
                end
            end
            result_idx++;
        end
    end

    // Result-side back-pressure in random bursts.
    always begin
        @(posedge i_clk);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            i_out_ready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        i_out_ready <= 1'b1;
    end

    task automatic send_req(input logic mode, input logic level, input logic [31:0] stamp);
        if (mode == swsfr_pkg::MODE_TICK || capturing)
            req_cnt++;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode <= mode;
        i_line_level <= level;
        i_cycle_stamp <= stamp;
        do @(posedge i_clk); while (!o_in_ready);
        reader_step(mode, level, stamp);
    endtask

    task automatic send_tick();
        send_req(swsfr_pkg::MODE_TICK, 1'($urandom_range(0, 1)), $urandom);
    endtask

    // Ticks the sequencer until a frame window is open, with stray edges in between.
    task automatic open_window();
        while (!capturing) begin
            if ($urandom_range(0, 7) == 0)
                send_req(swsfr_pkg::MODE_EDGE, 1'($urandom_range(0, 1)), $urandom);
            send_tick();
        end
    endtask

    // Sends a sensor answer: response fall, rise, first fall, then 40 bits.
    // With cut_at >= 0 the edge at that position arrives with the wrong level.
    task automatic send_frame(input bit good_sum, input int cut_at);
        logic [39:0] data;
        logic [31:0] lim;
        logic [31:0] hi;
        logic [7:0]  flip;
        bit          one;
        int          k;
        int          last;
        for (k = 1; k <= 4; k++) begin
            case ($urandom_range(0, 5))
                0: data[8*k +: 8] = 8'h00;
                1: data[8*k +: 8] = 8'hFF;
                default: data[8*k +: 8] = 8'($urandom_range(0, 255));
            endcase
        end
        data[7:0] = data[39:32] + data[31:24] + data[23:16] + data[15:8];
        flip = 8'($urandom_range(1, 255));
        if (!good_sum)
            data[7:0] = data[7:0] ^ flip;
        lim = bit_limit();
        // Often start close to the top so the stamp counter wraps inside the frame.
        if ($urandom_range(0, 3) == 0)
            line_ts = 32'd0 - $urandom_range(0, 20 * lim + 50000);
        else
            line_ts = $urandom;
        last = (cut_at < 0) ? FRAME_EDGES - 1 : cut_at;
        for (k = 0; k <= last; k++) begin
            if ($urandom_range(0, 399) == 0)
                send_tick();
            if (k == cut_at) begin
                send_req(swsfr_pkg::MODE_EDGE, !k[0], line_ts + $urandom_range(0, 2 * lim));
            end else if (k >= 4 && !k[0]) begin
                one = data[39 - (k - 4) / 2];
                if ($urandom_range(0, 3) == 0)
                    hi = one ? lim : lim - 32'd1;
                else
                    hi = one ? lim + $urandom_range(0, 2 * lim) : $urandom_range(0, lim - 1);
                send_req(swsfr_pkg::MODE_EDGE, 1'b0, line_ts + hi);
                line_ts = line_ts + hi + $urandom_range(1, 5000);
            end else begin
                send_req(swsfr_pkg::MODE_EDGE, k[0], line_ts);
                if (k < 3)
                    line_ts = line_ts + $urandom_range(1, 5000);
            end
        end
    endtask

    task automatic hold_idle();
        i_in_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic reg_access(input logic wr, input logic [2:0] idx, input logic [31:0] val,
                              output logic [31:0] rd);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rd = prdata;
        if (wr) begin
            case (idx)
                swsfr_pkg::REG_CYCLES_PER_US:   cfg_cpu = val[7:0];
                swsfr_pkg::REG_POWERUP_WAIT:    cfg_powerup = val[15:0];
                swsfr_pkg::REG_START_LOW:       cfg_start_low = val[15:0];
                swsfr_pkg::REG_SAMPLE_INTERVAL: cfg_interval = val[15:0];
                swsfr_pkg::REG_FRAME_TIMEOUT:   cfg_timeout = val[15:0];
                swsfr_pkg::REG_BIT_THRESHOLD:   cfg_thr = val[7:0];
                default: ;
            endcase
        end
    endtask

    task automatic check_regs();
        logic [31:0] rd;
        int          i;
        for (i = int'(swsfr_pkg::REG_CYCLES_PER_US); i <= int'(swsfr_pkg::REG_BIT_THRESHOLD);
             i++) begin
            reg_access(1'b0, i[2:0], 32'd0, rd);
            if (rd !== cfg_word(i[2:0])) begin
                if (mismatch_cnt < 10)
                    $display("register %0d: expected %0h, read %0h", i, cfg_word(i[2:0]), rd);
                mismatch_cnt++;
            end
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_config(input logic [7:0] cpu, input logic [15:0] powerup,
                              input logic [15:0] start_low, input logic [15:0] interval,
                              input logic [15:0] timeout, input logic [7:0] thr);
        logic [31:0] rd;
        hold_idle();
        reg_access(1'b1, swsfr_pkg::REG_CYCLES_PER_US, {24'd0, cpu}, rd);
        reg_access(1'b1, swsfr_pkg::REG_POWERUP_WAIT, {16'd0, powerup}, rd);
        reg_access(1'b1, swsfr_pkg::REG_START_LOW, {16'd0, start_low}, rd);
        reg_access(1'b1, swsfr_pkg::REG_SAMPLE_INTERVAL, {16'd0, interval}, rd);
        reg_access(1'b1, swsfr_pkg::REG_FRAME_TIMEOUT, {16'd0, timeout}, rd);
        reg_access(1'b1, swsfr_pkg::REG_BIT_THRESHOLD, {24'd0, thr}, rd);
        check_regs();
    endtask

    task automatic run_phase(input int n_req);
        int goal;
        goal = req_cnt + n_req;
        while (req_cnt < goal) begin
            open_window();
            case ($urandom_range(0, 9))
                0: send_frame(1'b1, int'($urandom_range(0, FRAME_EDGES - 1)));
                1: repeat ($urandom_range(1, 4)) send_tick();
                2: repeat ($urandom_range(1, 6)) send_req(swsfr_pkg::MODE_EDGE,
                                                          1'($urandom_range(0, 1)),
                                                          $urandom);
                default: send_frame($urandom_range(0, 3) != 0, -1);
            endcase
            send_tick();
        end
    endtask

    task automatic test_reset_regs();
        logic [31:0] rd;
        check_regs();
        reg_access(1'b1, REG_SPARE_A, $urandom, rd);
        reg_access(1'b1, REG_SPARE_B, $urandom, rd);
        check_regs();
    endtask

    // Power-up wait at its reset length, a zero-length start pulse, then a zero timeout.
    task automatic test_powerup();
        set_config(8'd0, 16'hFFFF, 16'd0, 16'd1, 16'd0, 8'd0);
        send_req(swsfr_pkg::MODE_EDGE, 1'b0, 32'h0000_0000);
        send_req(swsfr_pkg::MODE_EDGE, 1'b1, 32'hFFFF_FFFF);
        open_window();
        send_tick();
    endtask

    // A wrong-level edge at each capture state aborts the frame.
    task automatic test_capture_errors();
        int cuts[6];
        int j;
        cuts = '{0, 1, 2, 3, 4, FRAME_EDGES - 1};
        set_config(8'd1, 16'd0, 16'd1, 16'd0, 16'd2, 8'd0);
        for (j = 0; j < 6; j++) begin
            open_window();
            send_frame(1'b1, cuts[j]);
            send_req(swsfr_pkg::MODE_EDGE, 1'($urandom_range(0, 1)), $urandom);
            send_tick();
        end
    endtask

    task automatic test_frame_outcomes();
        set_config(8'd10, 16'd0, 16'd0, 16'd0, 16'd3, 8'd10);
        open_window();
        send_frame(1'b1, -1);
        send_tick();
        open_window();
        send_frame(1'b0, -1);
        send_tick();
        open_window();
        repeat (4) send_tick();
    endtask

    task automatic test_random_frames();
        set_config(8'd255, 16'd0, 16'd3, 16'd2, 16'hFFFF, 8'd255);
        run_phase(300);
        set_config(8'd1, 16'hFFFF, 16'd0, 16'd0, 16'd0, 8'd0);
        run_phase(250);
        set_config(8'd0, 16'd100, 16'd1, 16'd1, 16'd5, 8'($urandom_range(0, 255)));
        run_phase(250);
        set_config(8'($urandom_range(1, 255)), 16'($urandom_range(0, 65535)),
                   16'($urandom_range(0, 3)), 16'($urandom_range(0, 3)),
                   16'($urandom_range(0, 8)), 8'($urandom_range(0, 255)));
        run_phase(250);
    endtask

    // Wide counter loads: a full-range timeout and longer interval and start pulse
    // that run to completion.
    task automatic test_long_counts();
        idle_on = 1'b0;
        set_config(8'd200, 16'hFFFF, 16'd48, 16'd64, 16'hFFFF, 8'd255);
        open_window();
        send_frame(1'b1, -1);
        send_tick();
        open_window();
        send_tick();
    endtask

    task automatic test_quiet_tail();
        idle_on = 1'b0;
        set_config(8'd168, 16'd100, 16'd2, 16'd5, 16'd2, 8'd50);
        run_phase(200);
    endtask

    initial begin
        cfg_cpu = swsfr_pkg::RST_CYCLES_PER_US;
        cfg_powerup = swsfr_pkg::RST_POWERUP_WAIT;
        cfg_start_low = swsfr_pkg::RST_START_LOW;
        cfg_interval = swsfr_pkg::RST_SAMPLE_INTERVAL;
        cfg_timeout = swsfr_pkg::RST_FRAME_TIMEOUT;
        cfg_thr = swsfr_pkg::RST_BIT_THRESHOLD;
        seq_st = swsfr_pkg::SEQ_POWERUP;
        tick_left = swsfr_pkg::RST_POWERUP_WAIT;
        drop_capture();
        capturing = 1'b0;
        hum_keep = 12'd0;
        temp_keep = 12'd0;
        seen_good = 1'b0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_regs();
        test_powerup();
        test_capture_errors();
        test_frame_outcomes();
        test_random_frames();
        test_long_counts();
        test_quiet_tail();

        i_in_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
